### src/tqb_pkg.sv
// Package for the timeout queue: payload types, command codes and register indexes.
package tqb_pkg;

	// Payload field widths
	localparam int CMD_W = 2;
	localparam int SLOT_W = 6;
	localparam int NOW_W = 32;
	localparam int TIMEOUT_W = 32;
	localparam int COUNT_W = 16;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_THRESHOLD = 2'd1;

	// Register reset values and saturation limits
	localparam logic [TIMEOUT_W-1:0] INITIAL_TIMEOUT_RST = 32'd1000;
	localparam logic [COUNT_W-1:0] BACKOFF_THRESHOLD_RST = 16'd8;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX = 32'hFFFF_FFFF;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [SLOT_W-1:0] slot;
		logic [NOW_W-1:0] now_time;
	} tqb_in_t;

	typedef struct packed {
		logic expired;
		logic [SLOT_W-1:0] expired_slot;
		logic order_error;
	} tqb_out_t;

endpackage

### src/timeout_queue_with_backoff.sv
// Timeout queue: slot table kept as a timestamp-ordered doubly linked list in memory.
//
// Usage: commands arrive on the in_valid/in_ready channel (push, remove, check);
// each accepted command yields exactly one result transaction on out_valid/out_ready.
// Push links a slot in at the head with now_time (rejected with order_error when
// older than the head), remove unlinks a slot, check reports the tail slot when it
// has been waiting longer than the current timeout, with exponential backoff.
// Registers are written through the cfg_valid/cfg_ready channel (always ready).
// A check, a rejected push, a remove of an unlisted slot or an unused command
// goes from S_EVAL to S_DONE; a remove of a listed slot passes through S_UNLK and
// S_LINK, an accepted push also through S_FIX. The steps are set by the single
// write port of the link memory: an unlink and relink touch up to four entries,
// one write per cycle. One command is in flight at a time; the result sits in an
// output register, and a stalled receiver holds the block in its last step until
// that register frees up. Reset: head and tail go null and the timeout loads its
// reset value, then a clearing pass over all SLOTS entries marks every slot invalid;
// in_ready stays low until it ends. Configuration writes are taken throughout.
module timeout_queue_with_backoff #(
	parameter int SLOTS = 64,
	parameter int TIME_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input tqb_pkg::tqb_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output tqb_pkg::tqb_out_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [tqb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tqb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = IW + 1;
	localparam int TW = TIME_BITS;
	localparam int SW = tqb_pkg::SLOT_W;
	localparam int OW = tqb_pkg::TIMEOUT_W;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	typedef logic [LW-1:0] link_t;

	typedef struct packed {
		logic valid;
		link_t prev;
		link_t next;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic prev;
		logic next;
	} entry_mask_t;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_EVAL  = 7'b0000100,
		S_UNLK  = 7'b0001000,
		S_LINK  = 7'b0010000,
		S_FIX   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	// Memories
	entry_t link_mem [SLOTS];
	logic [TW-1:0] time_mem [SLOTS];

	state_t state_q;
	logic [IW-1:0] clr_q;
	logic [tqb_pkg::CMD_W-1:0] cmd_q;
	logic [SW-1:0] slot_q;
	logic [TW-1:0] t_q;
	link_t head_q, tail_q, hn_q, p_q, n_q;
	logic unl_q, push_q;
	entry_t link_rd_q;
	logic [TW-1:0] time_rd_q;
	logic [OW-1:0] cur_timeout_q;
	logic [tqb_pkg::COUNT_W-1:0] threshold_q, count_q;
	tqb_pkg::tqb_out_t res_q, out_q;
	logic out_valid_q;

	logic accept, out_free;
	logic [IW+SW-1:0] in_slot_ext, slot_ext;
	logic [IW-1:0] link_raddr, time_raddr, slot_idx;
	logic [TW+31:0] now_ext;
	link_t s_lk, hn, tn;
	logic slot_ok, sv, order_err, do_push, do_rem, do_check, exp_hit, bump;
	logic [TW-1:0] elapsed;
	logic [LW+SW-1:0] tail_ext;
	logic [tqb_pkg::COUNT_W-1:0] cnt1;
	logic [OW-1:0] doubled;

	logic lw_en;
	logic [IW-1:0] lw_addr;
	entry_mask_t lw_mask;
	entry_t lw_data;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign out_free = !out_valid_q || out_ready;

	// Read addresses, taken from the incoming transaction
	assign in_slot_ext = {{IW{1'b0}}, in_data.slot};
	assign link_raddr = in_slot_ext[IW-1:0];
	assign time_raddr = (in_data.cmd == tqb_pkg::CMD_CHECK) ? tail_q[IW-1:0] : head_q[IW-1:0];
	assign now_ext = {{TW{1'b0}}, in_data.now_time};

	// Registered reads
	always_ff @(posedge clk) begin
		link_rd_q <= link_mem[link_raddr];
		time_rd_q <= time_mem[time_raddr];
	end

	// Decode of the command against the entries read
	assign slot_ext = {{IW{1'b0}}, slot_q};
	assign slot_idx = slot_ext[IW-1:0];
	assign s_lk = {1'b0, slot_idx};
	assign slot_ok = ({{LW{1'b0}}, slot_q} < {{SW{1'b0}}, NIL});
	assign sv = slot_ok && link_rd_q.valid;
	assign order_err = (cmd_q == tqb_pkg::CMD_PUSH) && slot_ok && (head_q != NIL)
		&& (t_q < time_rd_q);
	assign do_push = (cmd_q == tqb_pkg::CMD_PUSH) && slot_ok && !order_err;
	assign do_rem = (cmd_q == tqb_pkg::CMD_REMOVE) && sv;
	assign hn = (sv && head_q == s_lk) ? link_rd_q.next : head_q;
	assign tn = (sv && tail_q == s_lk) ? link_rd_q.prev : tail_q;

	// Timeout check on the tail entry
	assign do_check = (cmd_q == tqb_pkg::CMD_CHECK) && (tail_q != NIL);
	assign elapsed = (t_q >= time_rd_q) ? (t_q - time_rd_q) : '0;
	assign exp_hit = do_check && ({32'b0, elapsed} > {{TW{1'b0}}, cur_timeout_q});
	assign cnt1 = (count_q != tqb_pkg::COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign bump = cnt1 > threshold_q;
	assign doubled = cur_timeout_q[OW-1] ? tqb_pkg::TIMEOUT_MAX : {cur_timeout_q[OW-2:0], 1'b0};
	assign tail_ext = {{SW{1'b0}}, tail_q};

	// Link memory write port, one entry per cycle with per-field enables
	always_comb begin
		lw_en = 1'b0;
		lw_addr = slot_idx;
		lw_mask = '0;
		lw_data = '{valid: 1'b0, prev: NIL, next: NIL};
		unique case (state_q)
			S_CLEAR: begin
				lw_en = 1'b1;
				lw_addr = clr_q;
				lw_mask = '1;
			end
			S_EVAL: begin
				lw_en = (do_push || do_rem) && sv && (link_rd_q.prev != NIL);
				lw_addr = link_rd_q.prev[IW-1:0];
				lw_mask.next = 1'b1;
				lw_data.next = link_rd_q.next;
			end
			S_UNLK: begin
				lw_en = unl_q && (n_q != NIL);
				lw_addr = n_q[IW-1:0];
				lw_mask.prev = 1'b1;
				lw_data.prev = p_q;
			end
			S_LINK: begin
				lw_en = 1'b1;
				lw_mask = '1;
				lw_data.valid = push_q;
				lw_data.next = push_q ? hn_q : NIL;
			end
			S_FIX: begin
				lw_en = (hn_q != NIL);
				lw_addr = hn_q[IW-1:0];
				lw_mask.prev = 1'b1;
				lw_data.prev = s_lk;
			end
			S_IDLE, S_DONE: begin
				lw_en = 1'b0;
			end
			default: begin
				lw_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (lw_en) begin
			if (lw_mask.valid) link_mem[lw_addr].valid <= lw_data.valid;
			if (lw_mask.prev) link_mem[lw_addr].prev <= lw_data.prev;
			if (lw_mask.next) link_mem[lw_addr].next <= lw_data.next;
		end
	end

	// Timestamp memory, written when a push links its slot
	always_ff @(posedge clk) begin
		if (state_q == S_LINK && push_q) begin
			time_mem[slot_idx] <= t_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) state_q <= S_EVAL;
				end
				S_EVAL: begin
					state_q <= (do_push || do_rem) ? S_UNLK : S_DONE;
				end
				S_UNLK: begin
					state_q <= S_LINK;
				end
				S_LINK: begin
					state_q <= push_q ? S_FIX : S_DONE;
				end
				S_FIX: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Transaction capture and per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_data.cmd;
			slot_q <= in_data.slot;
			t_q <= now_ext[TW-1:0];
		end
		if (state_q == S_EVAL) begin
			unl_q <= sv && (do_push || do_rem);
			push_q <= do_push;
			p_q <= link_rd_q.prev;
			n_q <= link_rd_q.next;
			hn_q <= hn;
			res_q.expired <= exp_hit;
			res_q.expired_slot <= exp_hit ? tail_ext[SW-1:0] : '0;
			res_q.order_error <= order_err;
		end
	end

	// Head and tail pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= NIL;
			tail_q <= NIL;
		end else if (state_q == S_EVAL && (do_push || do_rem)) begin
			head_q <= do_push ? s_lk : hn;
			tail_q <= (do_push && tn == NIL) ? s_lk : tn;
		end
	end

	// Timeout, backoff count and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_timeout_q <= tqb_pkg::INITIAL_TIMEOUT_RST;
			threshold_q <= tqb_pkg::BACKOFF_THRESHOLD_RST;
			count_q <= '0;
		end else begin
			if (state_q == S_EVAL && exp_hit) begin
				if (bump) begin
					count_q <= '0;
					cur_timeout_q <= doubled;
				end else begin
					count_q <= cnt1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tqb_pkg::CFG_INITIAL_TIMEOUT: begin
						cur_timeout_q <= cfg_data;
						count_q <= '0;
					end
					tqb_pkg::CFG_BACKOFF_THRESHOLD: begin
						threshold_q <= cfg_data[tqb_pkg::COUNT_W-1:0];
					end
					default: begin
						threshold_q <= threshold_q;
					end
				endcase
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) out_q <= res_q;
	end

	// Assertions
	a_head_tail_null: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (tail_q == NIL))
		else $error("head and tail disagree on an empty list");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second command accepted while one is in flight");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.expired && out_q.order_error))
		else $error("result reports both expiry and order error");

	a_expire_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.expired) |-> (out_q.expired_slot == '0))
		else $error("expired_slot set without expiry");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && out_q == $past(res_q)))
		else $error("result not loaded into output register");

endmodule

### tb/tqb_checker.sv
// Checker for the timeout queue: tracks the slot list and compares every result transaction.
module tqb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input tqb_pkg::tqb_in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input tqb_pkg::tqb_out_t out_data,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [tqb_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tqb_pkg::CFG_DATA_W-1:0] cfg_data,
	output int mismatches,
	output int outstanding,
	output int commands,
	output int expiries,
	output int rejects,
	output int backoffs
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;
	localparam int SW = tqb_pkg::SLOT_W;
	localparam int TOW = tqb_pkg::TIMEOUT_W;
	localparam int CNW = tqb_pkg::COUNT_W;
	localparam logic [SW:0] NIL = 7'd64;

	// Shadow of the slot table and the backoff state
	logic live [SLOTS];
	logic [SW:0] link_next [SLOTS];
	logic [SW:0] link_prev [SLOTS];
	logic [tqb_pkg::NOW_W-1:0] stamp [SLOTS];
	logic [SW:0] newest;
	logic [SW:0] oldest;
	logic [TOW-1:0] cur_timeout;
	logic [CNW-1:0] threshold;
	logic [CNW-1:0] timeout_cnt;

	tqb_pkg::tqb_out_t pending_results [$];
	int n_bad, n_cmd, n_exp, n_rej, n_dbl;

	function automatic void clear_list();
		for (int i = 0; i < SLOTS; i++) begin
			live[i] = 1'b0;
			link_next[i] = NIL;
			link_prev[i] = NIL;
			stamp[i] = '0;
		end
		newest = NIL;
		oldest = NIL;
		cur_timeout = tqb_pkg::INITIAL_TIMEOUT_RST;
		threshold = tqb_pkg::BACKOFF_THRESHOLD_RST;
		timeout_cnt = '0;
	endfunction

	// Take a slot out of the list; no effect when it is not listed
	function automatic void unlink_entry(input logic [SW-1:0] s);
		logic [SW:0] p, n;
		if (!live[s])
			return;
		p = link_prev[s];
		n = link_next[s];
		if (p != NIL)
			link_next[p[SW-1:0]] = n;
		if (n != NIL)
			link_prev[n[SW-1:0]] = p;
		if (newest == {1'b0, s})
			newest = n;
		if (oldest == {1'b0, s})
			oldest = p;
		link_next[s] = NIL;
		link_prev[s] = NIL;
		live[s] = 1'b0;
	endfunction

	// Apply one command to the shadow state and return the result it produces
	function automatic tqb_pkg::tqb_out_t apply_command(input tqb_pkg::tqb_in_t c);
		tqb_pkg::tqb_out_t r;
		logic [tqb_pkg::NOW_W-1:0] elapsed;
		logic [TOW:0] doubled;
		r = '0;
		case (c.cmd)
			tqb_pkg::CMD_PUSH: begin
				if (newest != NIL && c.now_time < stamp[newest[SW-1:0]]) begin
					r.order_error = 1'b1;
					n_rej++;
				end else begin
					unlink_entry(c.slot);
					live[c.slot] = 1'b1;
					link_prev[c.slot] = NIL;
					link_next[c.slot] = newest;
					stamp[c.slot] = c.now_time;
					if (newest != NIL)
						link_prev[newest[SW-1:0]] = {1'b0, c.slot};
					newest = {1'b0, c.slot};
					if (oldest == NIL)
						oldest = {1'b0, c.slot};
				end
			end
			tqb_pkg::CMD_REMOVE: begin
				unlink_entry(c.slot);
			end
			tqb_pkg::CMD_CHECK: begin
				if (oldest != NIL) begin
					// a check time older than the tail counts as no time elapsed
					if (c.now_time >= stamp[oldest[SW-1:0]])
						elapsed = c.now_time - stamp[oldest[SW-1:0]];
					else
						elapsed = '0;
					if (elapsed > cur_timeout) begin
						if (timeout_cnt != tqb_pkg::COUNT_MAX)
							timeout_cnt = timeout_cnt + 1'b1;
						if (timeout_cnt > threshold) begin
							doubled = {cur_timeout, 1'b0};
							timeout_cnt = '0;
							cur_timeout = doubled[TOW] ? tqb_pkg::TIMEOUT_MAX
								: doubled[TOW-1:0];
							n_dbl++;
						end
						r.expired = 1'b1;
						r.expired_slot = oldest[SW-1:0];
						n_exp++;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Watch the three channels; results are matched before new commands are queued
	always @(posedge clk or negedge arst_n) begin
		tqb_pkg::tqb_out_t want;
		if (!arst_n) begin
			clear_list();
			pending_results.delete();
			n_bad = 0;
			n_cmd = 0;
			n_exp = 0;
			n_rej = 0;
			n_dbl = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tqb_pkg::CFG_INITIAL_TIMEOUT: begin
						cur_timeout = cfg_data[TOW-1:0];
						timeout_cnt = '0;
					end
					tqb_pkg::CFG_BACKOFF_THRESHOLD: begin
						threshold = cfg_data[CNW-1:0];
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with no command outstanding: %p", out_data);
					n_bad++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.expired !== want.expired) begin
						$error("expired: expected %0d, got %0d", want.expired, out_data.expired);
						n_bad++;
					end
					if (out_data.expired_slot !== want.expired_slot) begin
						$error("expired_slot: expected %0d, got %0d",
							want.expired_slot, out_data.expired_slot);
						n_bad++;
					end
					if (out_data.order_error !== want.order_error) begin
						$error("order_error: expected %0d, got %0d",
							want.order_error, out_data.order_error);
						n_bad++;
					end
				end
			end
			if (in_valid && in_ready) begin
				pending_results.push_back(apply_command(in_data));
				n_cmd++;
			end
		end
		mismatches <= n_bad;
		outstanding <= pending_results.size();
		commands <= n_cmd;
		expiries <= n_exp;
		rejects <= n_rej;
		backoffs <= n_dbl;
	end

endmodule

### tb/testbench.sv
// Testbench top for the timeout queue: clock, reset, stimulus, output stalls and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = tqb_pkg::SLOT_W;
	localparam int NW = tqb_pkg::NOW_W;
	localparam logic [tqb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	tqb_pkg::tqb_in_t in_data;
	logic out_valid;
	logic out_ready;
	tqb_pkg::tqb_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [tqb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tqb_pkg::CFG_DATA_W-1:0] cfg_data;

	int mismatches, outstanding, commands, expiries, rejects, backoffs;

	// Gap control shared between the stimulus and the receiver
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;
	logic [NW-1:0] clock_ms;

	timeout_queue_with_backoff dut (.*);

	tqb_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run
	initial begin
		#20_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// Receiver: random stall per result, plus one long hold-off on request
	initial begin
		int hold;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				hold = rx_hold;
				rx_hold = 0;
			end else begin
				hold = rx_idle ? $urandom_range(0, 5) : 0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// One command transaction; valid stays high afterwards unless the caller drops it
	task automatic send(input logic [tqb_pkg::CMD_W-1:0] c, input logic [SW-1:0] s,
			input logic [NW-1:0] t);
		int gap;
		gap = tx_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{cmd: c, slot: s, now_time: t};
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	task automatic write_reg(input logic [tqb_pkg::CFG_IDX_W-1:0] idx,
			input logic [tqb_pkg::CFG_DATA_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering and wait for every outstanding result, then let the pipeline go quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Empty the list so the next phase can start from a fresh time base
	task automatic sweep();
		for (int k = 0; k < 64; k++)
			send(tqb_pkg::CMD_REMOVE, SW'(k), $urandom);
	endtask

	// Mostly in-order pushes with random removes and checks against the running time
	task automatic run_phase(input logic [tqb_pkg::TIMEOUT_W-1:0] init,
			input logic [tqb_pkg::COUNT_W-1:0] thr,
			input int n, input bit tx_i, input bit rx_i, input bit long_hold, input bit low_base);
		logic [NW-1:0] step, reach, t;
		logic [NW:0] sum;
		logic [SW-1:0] s;
		int pick, r;
		settle();
		write_reg(tqb_pkg::CFG_INITIAL_TIMEOUT, init);
		write_reg(tqb_pkg::CFG_BACKOFF_THRESHOLD, {16'd0, thr});
		tx_idle = tx_i;
		rx_idle = rx_i;
		sweep();
		step = init >> 3;
		if (step > 32'h0010_0000)
			step = 32'h0010_0000;
		if (step == 0)
			step = 1;
		reach = (init > 32'h1000_0000) ? 32'h4000_0000 : init * 32'd3;
		clock_ms = low_base ? $urandom_range(0, 1000) : $urandom_range(0, 32'hFFFF_FFFF - n * step);
		for (int i = 0; i < n; i++) begin
			if (long_hold && i == n / 4)
				rx_hold = 300;
			pick = $urandom_range(0, 99);
			s = ($urandom_range(0, 3) == 0) ? SW'($urandom_range(0, 3))
				: SW'($urandom_range(0, 63));
			if (pick < 42) begin
				// occasional stale timestamp to provoke an order error
				if ($urandom_range(0, 9) == 0 && clock_ms > step) begin
					t = clock_ms - $urandom_range(1, step);
				end else begin
					clock_ms = clock_ms + $urandom_range(0, step);
					t = clock_ms;
				end
				send(tqb_pkg::CMD_PUSH, s, t);
			end else if (pick < 62) begin
				send(tqb_pkg::CMD_REMOVE, s, $urandom);
			end else if (pick < 95) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					t = 32'hFFFF_FFFF;
				end else if (r == 1) begin
					t = $urandom_range(0, clock_ms);
				end else begin
					sum = {1'b0, clock_ms} + $urandom_range(0, reach);
					t = sum[NW] ? 32'hFFFF_FFFF : sum[NW-1:0];
				end
				send(tqb_pkg::CMD_CHECK, s, t);
			end else begin
				send(CMD_UNUSED, s, $urandom);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sequence at reset settings (timeout 1000, threshold 8)
		send(tqb_pkg::CMD_CHECK, 6'd0, 32'd0);
		send(tqb_pkg::CMD_REMOVE, 6'd5, 32'd0);
		send(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);
		send(tqb_pkg::CMD_PUSH, 6'd0, 32'd0);
		send(tqb_pkg::CMD_PUSH, 6'd63, 32'd100);
		send(tqb_pkg::CMD_PUSH, 6'd0, 32'd200);           // re-push of the tail
		send(tqb_pkg::CMD_PUSH, 6'd7, 32'd150);           // older than head: rejected
		send(tqb_pkg::CMD_PUSH, 6'd0, 32'd199);           // rejected even for the head itself
		send(tqb_pkg::CMD_CHECK, 6'd0, 32'd50);           // before the tail's time
		send(tqb_pkg::CMD_CHECK, 6'd0, 32'd1100);         // exactly at the timeout: no expiry
		send(tqb_pkg::CMD_CHECK, 6'd0, 32'd1101);
		send(tqb_pkg::CMD_CHECK, 6'd0, 32'hFFFF_FFFF);
		send(tqb_pkg::CMD_PUSH, 6'd63, 32'd300);
		send(tqb_pkg::CMD_PUSH, 6'd5, 32'hFFFF_FFFF);
		send(tqb_pkg::CMD_REMOVE, 6'd63, 32'd0);          // middle entry
		send(tqb_pkg::CMD_REMOVE, 6'd0, 32'd0);           // tail
		send(tqb_pkg::CMD_REMOVE, 6'd5, 32'd0);           // last entry
		send(tqb_pkg::CMD_CHECK, 6'd0, 32'hFFFF_FFFF);

		// Random phases across register settings
		run_phase(32'd1, 16'd0, 220, 1'b1, 1'b1, 1'b0, 1'b1);
		run_phase(32'd50, 16'd3, 250, 1'b0, 1'b1, 1'b0, 1'b0);
		run_phase(32'hFFFF_FFFF, 16'hFFFF, 120, 1'b1, 1'b0, 1'b0, 1'b0);
		run_phase(32'($urandom_range(1, 5000)), 16'($urandom_range(0, 20)), 250,
			1'b1, 1'b1, 1'b0, 1'b0);
		run_phase(32'd200, 16'd2, 230, 1'b1, 1'b1, 1'b1, 1'b0);
		run_phase(32'd1000, 16'd8, 280, 1'b0, 1'b0, 1'b0, 1'b0);

		// Build up the timeout count under the largest threshold, then lower the threshold
		settle();
		write_reg(tqb_pkg::CFG_INITIAL_TIMEOUT, 32'd1);
		write_reg(tqb_pkg::CFG_BACKOFF_THRESHOLD, 32'h0000_FFFF);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		sweep();
		send(tqb_pkg::CMD_PUSH, 6'd9, 32'd0);
		repeat (20) send(tqb_pkg::CMD_CHECK, SW'($urandom), 32'hFFFF_FFFF);
		settle();
		write_reg(tqb_pkg::CFG_BACKOFF_THRESHOLD, 32'd3);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (10) send(tqb_pkg::CMD_CHECK, SW'($urandom), 32'hFFFF_FFFF);

		settle();
		$display("covered %0d commands: %0d expirations, %0d rejected pushes, %0d doublings",
			commands, expiries, rejects, backoffs);
		$display("register extremes, a threshold lowered under a built-up count and a long "
			, "output stall were included");
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
